/* rtl/ps2rx_pkg.sv */
// Shared constants for the PS/2 host frame receiver.
// No dependencies; imported by ps2_host_frame_receiver_top.
`default_nettype none

package ps2rx_pkg;

    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 20;
    localparam int MINGAP_W  = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 4;
    localparam int BYTE_W    = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 1'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;
    localparam logic [MINGAP_W-1:0]  MIN_GAP_RESET = 16'd30;

    // Frame positions: idle, data bits 1..8, parity, stop.
    localparam logic [POS_W-1:0] POS_IDLE      = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST     = 4'd1;
    localparam logic [POS_W-1:0] POS_LAST_DATA = 4'd8;
    localparam logic [POS_W-1:0] POS_PARITY    = 4'd9;
    localparam logic [POS_W-1:0] POS_STOP      = 4'd10;

endpackage : ps2rx_pkg

`default_nettype wire

/* rtl/ps2_host_frame_receiver_top.sv */
// An input item is held in the input register until the frame state takes it; a
// good frame end also loads the result register. Throughput: one input item per
// cycle while in_stall is low; frame state is updated once per item.
// Reset (rst_n low, asynchronous) clears frame state, the pipeline valids and the
// configuration registers to their defaults (timeout 20000 us, minimum gap 30 us).
`default_nettype none

module ps2_host_frame_receiver_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [ps2rx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ps2rx_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [ps2rx_pkg::TIME_W-1:0]       now_us,
    input  wire logic                               clk_level,
    input  wire logic                               data_level,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [ps2rx_pkg::BYTE_W-1:0]            rx_byte
);
    import ps2rx_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [MINGAP_W-1:0]  min_gap_reg;

    // Input register.
    logic              s1_valid_reg, s1_valid_next;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_clk_reg;
    logic              s1_data_reg;

    // Frame state.
    logic [TIME_W-1:0] last_edge_reg, last_edge_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              par_reg, par_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] rx_byte_reg, rx_byte_next;

    logic              out_free;
    logic              in_take;
    logic              s1_go;
    logic              emit;
    logic              line_reset;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;
    logic              gap_ok;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  pos_dec;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign s1_go     = s1_valid_reg && out_free;
    assign out_valid = out_valid_reg;
    assign rx_byte   = rx_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            min_gap_reg <= MIN_GAP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                REG_MIN_GAP: min_gap_reg <= cfg_data[MINGAP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_now_reg  <= now_us;
            s1_clk_reg  <= clk_level;
            s1_data_reg <= data_level;
        end
    end

    // Differences wrap modulo 2^32. A zero edge time means no edge yet and
    // disables the timeout.
    assign line_reset = !s1_clk_reg && s1_data_reg;
    assign elapsed    = s1_now_reg - last_edge_reg;
    assign timed_out  = (last_edge_reg != '0)
                        && (elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg});
    assign gap_ok     = elapsed >= {{(TIME_W-MINGAP_W){1'b0}}, min_gap_reg};
    assign pos_eff    = timed_out ? POS_IDLE : pos_reg;
    assign pos_dec    = pos_eff - POS_FIRST;

    always_comb
    begin
        last_edge_next = last_edge_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        par_next       = par_reg;
        emit           = 1'b0;
        if (line_reset)
        begin
            last_edge_next = s1_now_reg;
            pos_next       = POS_IDLE;
            shift_next     = '0;
            par_next       = 1'b1;
        end
        else
        begin
            pos_next = pos_eff;
            if (s1_clk_reg)
            begin
                if (pos_eff == POS_IDLE)
                begin
                    if (!s1_data_reg)
                    begin
                        pos_next       = POS_FIRST;
                        last_edge_next = s1_now_reg;
                    end
                end
                else if (gap_ok)
                begin
                    last_edge_next = s1_now_reg;
                    if (pos_eff <= POS_LAST_DATA)
                    begin
                        // Data bits arrive LSB first.
                        if (s1_data_reg)
                        begin
                            shift_next = shift_reg
                                         | (BYTE_W'(1) << pos_dec[2:0]);
                            par_next   = !par_reg;
                        end
                        pos_next = pos_eff + POS_FIRST;
                    end
                    else if (pos_eff == POS_PARITY)
                    begin
                        if (s1_data_reg)
                        begin
                            par_next = !par_reg;
                        end
                        pos_next = POS_STOP;
                    end
                    else if (pos_eff == POS_STOP)
                    begin
                        pos_next = POS_IDLE;
                        emit     = s1_data_reg && !par_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            pos_reg       <= POS_IDLE;
            shift_reg     <= '0;
            par_reg       <= 1'b1;
        end
        else if (s1_go)
        begin
            last_edge_reg <= last_edge_next;
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            par_reg       <= par_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rx_byte_next   = rx_byte_reg;
        if (out_free)
        begin
            out_valid_next = s1_go && emit;
            if (s1_go && emit)
            begin
                rx_byte_next = shift_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_byte_reg <= rx_byte_next;
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_STOP)
        else $error("frame position out of range");

    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && line_reset) |=> (pos_reg == POS_IDLE && par_reg && shift_reg == '0))
        else $error("line reset did not clear the frame");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without a pending item");

    a_emit_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && emit) |=> (pos_reg == POS_IDLE && out_valid_reg))
        else $error("result emitted without frame end");
`endif

endmodule : ps2_host_frame_receiver_top

`default_nettype wire
